// File: hw/rtl/packed_17bit_3d_store_assert.svh
// Assertion macros for the packed 17-bit 3D store.
// Used by the top level; relies on clk and rst_n in the including scope.
`ifndef PACKED_17BIT_3D_STORE_ASSERT_SVH
`define PACKED_17BIT_3D_STORE_ASSERT_SVH

`ifndef SYNTHESIS

`define P17S_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define P17S_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define P17S_ASSERT_IMP(name, ante, cons, msg)

`define P17S_ASSERT_NXT(name, ante, cons, msg)

`endif

`endif

// File: hw/rtl/p17s_pkg.sv
// Shared widths, codes and types for the packed 17-bit 3D store.
// No dependencies.
package p17s_pkg;

  localparam int ELEM_W  = 17;
  localparam int ELEM_BITS = 17;
  localparam int BYTE_W  = 8;
  localparam int WIN_W   = 24;
  localparam int COORD_W = 13;
  localparam int DIM_W   = 13;
  localparam int VAL_W   = 32;
  localparam int ST_W    = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_INDEX = 2'd1;
  localparam logic [ST_W-1:0] ST_BIG   = 2'd2;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_DIM_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_Z = 2'd2;

  // index unit status toward the sequencer
  typedef struct packed {
    logic       done;
    logic       err;
    logic [2:0] offs;
  } p17s_ix_stat_t;

endpackage

// File: hw/rtl/p17s_if.sv
// Valid/ready channel interfaces for access items and result items.
// Depends on p17s_pkg.
interface p17s_in_if import p17s_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic signed [COORD_W-1:0] coord_z;
  logic [VAL_W-1:0]          write_value;

  modport source (output valid, operation, coord_x, coord_y, coord_z, write_value,
                  input ready);
  modport sink (input valid, operation, coord_x, coord_y, coord_z, write_value,
                output ready);
endinterface

interface p17s_out_if import p17s_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ELEM_W-1:0] read_value;
  logic [ST_W-1:0]   status;

  modport source (output valid, read_value, status, input ready);
  modport sink (input valid, read_value, status, output ready);
endinterface

// File: hw/rtl/p17s_mem.sv
// Byte-wide simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module p17s_mem #(
  parameter int DEPTH  = 8705,
  parameter int ADDR_W = 14
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [7:0]        wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [7:0]        rdata
);

  logic [7:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem_r[raddr];
  end

endmodule

// File: hw/rtl/p17s_index.sv
// Four-stage index pipeline: bounds check, linear index, bit position.
// Depends on p17s_pkg.
module p17s_index import p17s_pkg::*; #(
  parameter int MAX_ENTRIES = 4096,
  parameter int ADDR_W      = 14
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic signed [COORD_W-1:0] coord_x,
  input  logic signed [COORD_W-1:0] coord_y,
  input  logic signed [COORD_W-1:0] coord_z,
  input  logic [DIM_W-1:0]          dim_x,
  input  logic [DIM_W-1:0]          dim_y,
  input  logic [DIM_W-1:0]          dim_z,
  output logic [ADDR_W-1:0]         byte_addr,
  output p17s_ix_stat_t             stat
);

  localparam int CM_W   = COORD_W - 1;          // magnitude of a valid coordinate
  localparam int YP_W   = CM_W + DIM_W;
  localparam int DXY_W  = 2 * DIM_W;
  localparam int ZP_W   = CM_W + DXY_W;
  localparam int S2_W   = YP_W + 1;
  localparam int IDXF_W = ZP_W + 1;
  localparam int IDX_W  = $clog2(MAX_ENTRIES + 1);
  localparam int BP_W   = $clog2(MAX_ENTRIES * ELEM_BITS);
  localparam logic [IDXF_W-1:0] MAX_IDX = IDXF_W'(MAX_ENTRIES);

  logic v1_r, v2_r, v3_r, v4_r;
  logic err1_r, err2_r, err3_r, err4_r;
  logic [CM_W-1:0]   x1_r, z1_r;
  logic [YP_W-1:0]   yp1_r;
  logic [DXY_W-1:0]  dxy1_r;
  logic [ZP_W-1:0]   zp2_r;
  logic [S2_W-1:0]   s2_r;
  logic [IDXF_W-1:0] idx3_r;
  logic [IDXF_W-1:0] idx_sum;
  logic [BP_W-1:0]   bp4_r;
  logic x_ok, y_ok, z_ok;

  assign x_ok = !coord_x[COORD_W-1] && (DIM_W'(coord_x[CM_W-1:0]) < dim_x);
  assign y_ok = !coord_y[COORD_W-1] && (DIM_W'(coord_y[CM_W-1:0]) < dim_y);
  assign z_ok = !coord_z[COORD_W-1] && (DIM_W'(coord_z[CM_W-1:0]) < dim_z);
  assign idx_sum = IDXF_W'(s2_r) + IDXF_W'(zp2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    // stage 1: range check and first products
    err1_r <= !(x_ok && y_ok && z_ok);
    x1_r   <= coord_x[CM_W-1:0];
    z1_r   <= coord_z[CM_W-1:0];
    yp1_r  <= YP_W'(coord_y[CM_W-1:0]) * YP_W'(dim_x);
    dxy1_r <= DXY_W'(dim_x) * DXY_W'(dim_y);
    // stage 2: z plane product, row sum
    err2_r <= err1_r;
    zp2_r  <= ZP_W'(z1_r) * ZP_W'(dxy1_r);
    s2_r   <= S2_W'(x1_r) + S2_W'(yp1_r);
    // stage 3: linear index and capacity check
    err3_r <= err2_r || (idx_sum >= MAX_IDX);
    idx3_r <= idx_sum;
    // stage 4: bit position = index * 17
    err4_r <= err3_r;
    bp4_r  <= (BP_W'(idx3_r[IDX_W-1:0]) << 4) + BP_W'(idx3_r[IDX_W-1:0]);
  end

  assign byte_addr = ADDR_W'(bp4_r >> 3);
  assign stat.done = v4_r;
  assign stat.err  = err4_r;
  assign stat.offs = bp4_r[2:0];

endmodule

// File: hw/rtl/packed_17bit_3d_store.sv
// Packed 17-bit 3D store: one access item in, one result item out.
// An in-range access passes the 4-stage index pipeline, the byte read-modify-write and
// the push; an index error or oversized value skips the read-modify-write.
// One item at a time: no new item is taken until the result has been pushed, and the
// push waits only while the previous result still waits on out_ch.ready.
// Reset: all STORE_BYTES RAM bytes (8705 by default) cleared, no item taken meanwhile.
module packed_17bit_3d_store import p17s_pkg::*; #(
  parameter int MAX_ENTRIES = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  p17s_in_if.sink              in_ch,
  p17s_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_wdata
);

`include "packed_17bit_3d_store_assert.svh"

  localparam int STORE_BYTES = (MAX_ENTRIES * ELEM_BITS) / BYTE_W + 1;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,   // zeroing pass after reset
    S_IDLE  = 5'b00010,   // ready for an item
    S_INDEX = 5'b00100,   // waiting on the index pipeline
    S_RMW   = 5'b01000,   // three byte reads, each written back in the next cycle
    S_PUSH  = 5'b10000    // hand result to the output register
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [DIM_W-1:0] dim_x_r, dim_y_r, dim_z_r;

  // control
  logic [ADDR_W-1:0] clr_r;
  logic [1:0]        cnt_r;
  logic              out_valid_r;

  // item payload
  logic              op_r;
  logic              big_r;
  logic [ELEM_W-1:0] wv_r;
  logic [ADDR_W-1:0] b0_r;
  logic [2:0]        offs_r;
  logic [WIN_W-1:0]  wmask_r, wval_r;
  logic [15:0]       win_r;
  logic [ADDR_W-1:0] rd_addr_q_r;
  logic [ELEM_W-1:0] res_rv_r, out_rv_r;
  logic [ST_W-1:0]   res_st_r, out_st_r;

  // RAM and index unit hookup
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata, mem_rdata;
  logic [ADDR_W-1:0] ix_addr;
  p17s_ix_stat_t     ix_stat;

  logic              in_acc;
  logic              push_ok;
  logic [1:0]        byte_sel;
  logic [WIN_W-1:0]  rd_win;
  logic [ELEM_W-1:0] rd_val;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign push_ok     = !out_valid_r || out_ch.ready;

  // byte of the window whose read data lands this cycle
  assign byte_sel = 2'(cnt_r - 2'd1);
  assign rd_win   = {mem_rdata, win_r};
  assign rd_val   = ELEM_W'(rd_win >> offs_r);

  p17s_index #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .ADDR_W      (ADDR_W)
  ) u_index (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_acc),
    .coord_x   (in_ch.coord_x),
    .coord_y   (in_ch.coord_y),
    .coord_z   (in_ch.coord_z),
    .dim_x     (dim_x_r),
    .dim_y     (dim_y_r),
    .dim_z     (dim_z_r),
    .byte_addr (ix_addr),
    .stat      (ix_stat)
  );

  p17s_mem #(
    .DEPTH  (STORE_BYTES),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // RAM port control: clear sweep, or write back the byte read in the previous cycle
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_r;
    mem_wdata = '0;
    mem_raddr = b0_r + ADDR_W'(cnt_r);
    if (state_r == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (state_r == S_RMW && op_r == OP_WRITE && cnt_r != 2'd0) begin
      mem_we    = 1'b1;
      mem_waddr = rd_addr_q_r;
      mem_wdata = (mem_rdata & ~wmask_r[8*byte_sel +: 8]) | wval_r[8*byte_sel +: 8];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_r == LAST_ADDR) state_nxt = S_IDLE;
      S_IDLE:  if (in_acc) state_nxt = S_INDEX;
      S_INDEX: begin
        if (ix_stat.done) begin
          if (ix_stat.err || (op_r == OP_WRITE && big_r)) state_nxt = S_PUSH;
          else state_nxt = S_RMW;
        end
      end
      S_RMW:   if (cnt_r == 2'd3) state_nxt = S_PUSH;
      S_PUSH:  if (push_ok) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      dim_x_r     <= DIM_W'(1);
      dim_y_r     <= DIM_W'(1);
      dim_z_r     <= DIM_W'(1);
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + ADDR_W'(1);
      if (state_r == S_RMW) cnt_r <= cnt_r + 2'd1;
      else cnt_r <= '0;
      if (state_r == S_PUSH && push_ok) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DIM_X: dim_x_r <= cfg_wdata;
          CFG_DIM_Y: dim_y_r <= cfg_wdata;
          CFG_DIM_Z: dim_z_r <= cfg_wdata;
          default: ;   // index beyond the register list is dropped
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_addr_q_r <= mem_raddr;
    if (in_acc) begin
      op_r  <= in_ch.operation;
      wv_r  <= in_ch.write_value[ELEM_W-1:0];
      big_r <= |in_ch.write_value[VAL_W-1:ELEM_W];
    end
    if (state_r == S_INDEX && ix_stat.done) begin
      b0_r     <= ix_addr;
      offs_r   <= ix_stat.offs;
      wmask_r  <= {{(WIN_W-ELEM_W){1'b0}}, {ELEM_W{1'b1}}} << ix_stat.offs;
      wval_r   <= WIN_W'(wv_r) << ix_stat.offs;
      res_rv_r <= '0;
      // index check wins over the value check
      if (ix_stat.err) res_st_r <= ST_INDEX;
      else if (op_r == OP_WRITE && big_r) res_st_r <= ST_BIG;
      else res_st_r <= ST_OK;
    end
    if (state_r == S_RMW) begin
      if (cnt_r == 2'd1) win_r[7:0] <= mem_rdata;
      if (cnt_r == 2'd2) win_r[15:8] <= mem_rdata;
      if (cnt_r == 2'd3) res_rv_r <= (op_r == OP_WRITE) ? '0 : rd_val;
    end
    if (state_r == S_PUSH && push_ok) begin
      out_rv_r <= res_rv_r;
      out_st_r <= res_st_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = out_rv_r;
  assign out_ch.status     = out_st_r;

  // RAM writes during an access only come from write items
  `P17S_ASSERT_IMP(a_rmw_write_op, (state_r == S_RMW) && mem_we, op_r == OP_WRITE, "RAM write on read item")
  // a failed access never carries data
  `P17S_ASSERT_IMP(a_err_no_data, out_ch.valid && (out_ch.status != ST_OK), out_ch.read_value == '0, "nonzero value with error status")
  // an index error skips the RAM entirely
  `P17S_ASSERT_NXT(a_err_skips_rmw, (state_r == S_INDEX) && ix_stat.done && ix_stat.err, state_r == S_PUSH, "index error entered RMW")

endmodule
